>>> design/bridge_find_edge_orient_unit_assert.svh
// assertion macros for the bridge finding unit
`ifndef BRIDGE_FIND_EDGE_ORIENT_UNIT_ASSERT_SVH
`define BRIDGE_FIND_EDGE_ORIENT_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define BFEO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication whose consequent is checked in the next cycle
`define BFEO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/bfeo_pkg.sv
package bfeo_pkg;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_START,
    ST_TOP,
    ST_ENTRY,
    ST_DECIDE,
    ST_POP,
    ST_POP_ENTRY,
    ST_EMIT_RD,
    ST_EMIT,
    ST_CLEAR
  } state_e;

endpackage

>>> design/bridge_find_edge_orient_unit.sv
// Bridge finding and strong orientation of a small undirected multigraph.
// Edges stream in on the slave side, one item each, endpoints end_a/end_b.
// Each item, up to MAX_EDGES, is stored (ends for reporting, both directions in
// an adjacency store when in range). The item with tlast set starts a depth-first
// search from node 1, run by one sequencer over node tables and an explicit stack
// held in flip-flops and small memories; a parent link is skipped once, so parallel
// edges form cycles. A non-bridge edge u-v is oriented u->v when low[v] <= dfn[u].
// Then one result per stored edge leaves in input order: the orientation,
// or the ends as given with is_bridge set.
// Loading: s_axis_tready drops while the second direction of an edge goes into
// the adjacency store, written the cycle after the first. After the final item
// come the search (one adjacency memory read port), the results and the table
// clearing, all while s_axis_tready is low.
// node_count is to be written through cfg_we_i only while the unit is idle;
// the unit itself does not enforce this.
module bridge_find_edge_orient_unit #(
  parameter int MAX_NODES = 32,
  parameter int MAX_EDGES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // end_a [5:0], end_b [11:6]
  input  logic        s_axis_tlast,  // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // edge_index, from_node, to_node
  output logic        m_axis_tuser,  // is_bridge
  output logic        m_axis_tlast   // last_result
);

  `include "bridge_find_edge_orient_unit_assert.svh"

  localparam int NW = $clog2(MAX_NODES + 1);   // node index
  localparam int EW = $clog2(MAX_EDGES + 1);   // edge count
  localparam int IW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int AW = IW + 1;                   // adjacency slot
  localparam int SW = $clog2(MAX_NODES + 1);    // stack pointer
  localparam int XW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int ENW = 1 + AW + NW + IW;        // entry: valid next, next, to, id

  bfeo_pkg::state_e state_q, state_d;

  logic [5:0] node_count_q;
  logic [NW-1:0] lim;
  assign lim = (node_count_q > 6'(MAX_NODES)) ? NW'(MAX_NODES) : NW'(node_count_q);

  // node tables in flip-flops, indexed by node number 1..MAX_NODES
  logic [MAX_NODES:1]     head_v_q;
  logic [AW-1:0]          head_q  [1:MAX_NODES];
  logic [NW-1:0]          dfn_q   [1:MAX_NODES];
  logic [NW-1:0]          low_q   [1:MAX_NODES];
  logic [MAX_EDGES-1:0]   ori_q;
  logic [NW-1:0]          tnow_q;
  logic [EW-1:0]          ecnt_q;

  // stack frames
  logic [NW-1:0] sk_node_q [MAX_NODES];
  logic [NW-1:0] sk_par_q  [MAX_NODES];
  logic [AW-1:0] sk_cur_q  [MAX_NODES];
  logic          sk_cv_q   [MAX_NODES];
  logic          sk_skip_q [MAX_NODES];
  logic [SW-1:0] sp_q;

  logic [NW-1:0] clr_q;
  logic [IW-1:0] oidx_q;

  // adjacency memory
  logic          adj_we;
  logic [AW-1:0] adj_wa, adj_ra;
  logic [ENW-1:0] adj_wd, adj_rd;
  bfeo_ram #(.Depth(2 * MAX_EDGES), .Width(ENW)) u_adj (
    .clk_i, .we_i(adj_we), .waddr_i(adj_wa), .wdata_i(adj_wd),
    .raddr_i(adj_ra), .rdata_o(adj_rd)
  );
  // edge memory: ends as given, and chosen direction
  logic          ed_we, dir_we;
  logic [IW-1:0] ed_wa, dir_wa, ed_ra;
  logic [11:0]   ed_rd, dir_wd, dir_rd;
  bfeo_ram #(.Depth(MAX_EDGES), .Width(12)) u_ends (
    .clk_i, .we_i(ed_we), .waddr_i(ed_wa), .wdata_i(s_axis_tdata[11:0]),
    .raddr_i(ed_ra), .rdata_o(ed_rd)
  );
  bfeo_ram #(.Depth(MAX_EDGES), .Width(12)) u_dir (
    .clk_i, .we_i(dir_we), .waddr_i(dir_wa), .wdata_i(dir_wd),
    .raddr_i(ed_ra), .rdata_o(dir_rd)
  );

  // decoded read entry
  logic          e_nv;
  logic [AW-1:0] e_next;
  logic [NW-1:0] e_to;
  logic [IW-1:0] e_id;
  assign {e_nv, e_next, e_to, e_id} = adj_rd;

  // top frame
  logic [XW-1:0] top, par;
  assign top = XW'(sp_q - SW'(1));
  assign par = XW'(sp_q - SW'(2));
  logic [NW-1:0] u_n, v_n;
  assign u_n = sk_node_q[top];
  assign v_n = e_to;

  logic [5:0] in_a, in_b;
  assign in_a = s_axis_tdata[5:0];
  assign in_b = s_axis_tdata[11:6];
  logic in_ok;
  assign in_ok = (in_a >= 6'd1) && (NW'(in_a) <= lim) && (in_a <= 6'(MAX_NODES))
              && (in_b >= 6'd1) && (NW'(in_b) <= lim) && (in_b <= 6'(MAX_NODES));
  logic acc, store;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign store = acc && (ecnt_q < EW'(MAX_EDGES));
  // second adjacency write follows the first in the next cycle
  logic ins2_q;
  logic [NW-1:0] ins_b_q;
  logic [NW-1:0] ins_a_q;
  logic [IW-1:0] ins_id_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bfeo_pkg::ST_LOAD:
        if (acc && s_axis_tlast) state_d = bfeo_pkg::ST_START;
      bfeo_pkg::ST_START:
        if (ins2_q) state_d = bfeo_pkg::ST_START;
        else if (lim == '0) state_d = (ecnt_q == '0) ? bfeo_pkg::ST_CLEAR
                                                    : bfeo_pkg::ST_EMIT_RD;
        else state_d = bfeo_pkg::ST_TOP;
      bfeo_pkg::ST_TOP:
        if (sp_q == '0) state_d = (ecnt_q == '0) ? bfeo_pkg::ST_CLEAR
                                                 : bfeo_pkg::ST_EMIT_RD;
        else if (!sk_cv_q[top]) state_d = bfeo_pkg::ST_POP;
        else state_d = bfeo_pkg::ST_ENTRY;
      bfeo_pkg::ST_ENTRY:  state_d = bfeo_pkg::ST_DECIDE;
      bfeo_pkg::ST_DECIDE: state_d = bfeo_pkg::ST_TOP;
      bfeo_pkg::ST_POP:
        state_d = (sp_q == SW'(1)) ? bfeo_pkg::ST_TOP : bfeo_pkg::ST_POP_ENTRY;
      bfeo_pkg::ST_POP_ENTRY: state_d = bfeo_pkg::ST_TOP;
      bfeo_pkg::ST_EMIT_RD: state_d = bfeo_pkg::ST_EMIT;
      bfeo_pkg::ST_EMIT:
        if (m_axis_tready || !m_axis_tvalid) begin
          state_d = (EW'(oidx_q) + EW'(1) == ecnt_q) ? bfeo_pkg::ST_CLEAR
                                                     : bfeo_pkg::ST_EMIT_RD;
        end
      bfeo_pkg::ST_CLEAR:
        if (clr_q == NW'(MAX_NODES) && !m_axis_tvalid) state_d = bfeo_pkg::ST_LOAD;
      default: state_d = bfeo_pkg::ST_LOAD;
    endcase
  end

  // memory controls
  always_comb begin
    adj_we = 1'b0;
    adj_wa = '0;
    adj_wd = '0;
    adj_ra = sk_cur_q[top];
    ed_we  = store;
    ed_wa  = IW'(ecnt_q);
    ed_ra  = oidx_q;
    if (state_q == bfeo_pkg::ST_POP) adj_ra = sk_cur_q[par];
    if (ins2_q) begin
      adj_we = 1'b1;
      adj_wa = {ins_id_q, 1'b1};
      adj_wd = {head_v_q[ins_b_q], head_q[ins_b_q], ins_a_q, ins_id_q};
    end else if (store && in_ok && state_q == bfeo_pkg::ST_LOAD) begin
      adj_we = 1'b1;
      adj_wa = {IW'(ecnt_q), 1'b0};
      adj_wd = {head_v_q[NW'(in_a)], head_q[NW'(in_a)], NW'(in_b), IW'(ecnt_q)};
    end
  end

  // low/orient update for node u and neighbour v via edge id (parent u, child v on a pop)
  logic          after;
  logic [NW-1:0] af_u, af_v;
  logic [IW-1:0] af_id;
  logic          push;
  logic          pop_ok;
  always_comb begin
    after  = 1'b0;
    push   = 1'b0;
    af_u   = u_n;
    af_v   = v_n;
    af_id  = e_id;
    if (state_q == bfeo_pkg::ST_DECIDE) begin
      if (!(v_n == sk_par_q[top] && sk_skip_q[top])) begin
        if (dfn_q[v_n] != '0 || sp_q >= SW'(MAX_NODES)) after = 1'b1;
        else push = 1'b1;
      end
    end
    pop_ok = (state_q == bfeo_pkg::ST_POP_ENTRY);
    if (pop_ok) begin
      after = 1'b1;
      af_u  = sk_node_q[par];
      af_v  = sk_node_q[top];
    end
    dir_we = after && (low_q[af_v] <= dfn_q[af_u]) && !ori_q[af_id];
    dir_wa = af_id;
    dir_wd = {6'(af_v), 6'(af_u)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bfeo_pkg::ST_LOAD;
      node_count_q <= 6'd32;
      head_v_q     <= '0;
      ori_q        <= '0;
      tnow_q       <= '0;
      ecnt_q       <= '0;
      sp_q         <= '0;
      clr_q        <= NW'(1);
      oidx_q       <= '0;
      ins2_q       <= 1'b0;
      m_axis_tvalid <= 1'b0;
      for (int i = 1; i <= MAX_NODES; i++) dfn_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) node_count_q <= cfg_wdata_i;
      ins2_q <= adj_we && !ins2_q;
      if (m_axis_tvalid && m_axis_tready && state_q != bfeo_pkg::ST_EMIT) begin
        m_axis_tvalid <= 1'b0;
      end
      if (adj_we) begin
        if (ins2_q) begin
          head_q[ins_b_q]   <= adj_wa;
          head_v_q[ins_b_q] <= 1'b1;
        end else begin
          head_q[NW'(in_a)]   <= adj_wa;
          head_v_q[NW'(in_a)] <= 1'b1;
          ins_a_q  <= NW'(in_a);
          ins_b_q  <= NW'(in_b);
          ins_id_q <= IW'(ecnt_q);
        end
      end
      if (store) ecnt_q <= ecnt_q + EW'(1);
      if (dir_we) ori_q[af_id] <= 1'b1;
      if (after && low_q[af_v] < low_q[af_u]) low_q[af_u] <= low_q[af_v];
      unique case (state_q)
        bfeo_pkg::ST_START:
          if (!ins2_q && lim != '0) begin
            tnow_q        <= NW'(1);
            dfn_q[1]      <= NW'(1);
            low_q[1]      <= NW'(1);
            sk_node_q[0]  <= NW'(1);
            sk_par_q[0]   <= '0;
            sk_cur_q[0]   <= head_q[1];
            sk_cv_q[0]    <= head_v_q[1];
            sk_skip_q[0]  <= 1'b1;
            sp_q          <= SW'(1);
          end
        bfeo_pkg::ST_DECIDE:
          if (push) begin
            tnow_q              <= tnow_q + NW'(1);
            dfn_q[v_n]          <= tnow_q + NW'(1);
            low_q[v_n]          <= tnow_q + NW'(1);
            sk_node_q[XW'(sp_q)] <= v_n;
            sk_par_q[XW'(sp_q)]  <= u_n;
            sk_cur_q[XW'(sp_q)]  <= head_q[v_n];
            sk_cv_q[XW'(sp_q)]   <= head_v_q[v_n];
            sk_skip_q[XW'(sp_q)] <= 1'b1;
            sp_q                <= sp_q + SW'(1);
          end else begin
            if (v_n == sk_par_q[top] && sk_skip_q[top]) sk_skip_q[top] <= 1'b0;
            sk_cur_q[top] <= e_next;
            sk_cv_q[top]  <= e_nv;
          end
        bfeo_pkg::ST_POP:
          if (sp_q == SW'(1)) sp_q <= '0;
        bfeo_pkg::ST_POP_ENTRY: begin
          sk_cur_q[par] <= e_next;
          sk_cv_q[par]  <= e_nv;
          sp_q          <= sp_q - SW'(1);
        end
        bfeo_pkg::ST_EMIT:
          if (m_axis_tready || !m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {6'd0, ori_q[oidx_q] ? dir_rd : ed_rd, 6'(oidx_q)};
            m_axis_tuser  <= !ori_q[oidx_q];
            m_axis_tlast  <= (EW'(oidx_q) + EW'(1) == ecnt_q);
            oidx_q        <= oidx_q + IW'(1);
          end
        bfeo_pkg::ST_CLEAR: begin
          dfn_q[clr_q]    <= '0;
          head_v_q[clr_q] <= 1'b0;
          if (clr_q != NW'(MAX_NODES)) clr_q <= clr_q + NW'(1);
          else if (!m_axis_tvalid) begin
            clr_q  <= NW'(1);
            ecnt_q <= '0;
            oidx_q <= '0;
            ori_q  <= '0;
            tnow_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // dir memory holds {to, from}; emitted order is from then to
  assign s_axis_tready = (state_q == bfeo_pkg::ST_LOAD) && !ins2_q;

  `BFEO_ASSERT_IMP(a_no_accept_busy, state_q != bfeo_pkg::ST_LOAD, !s_axis_tready)
  `BFEO_ASSERT_IMP(a_sp_bound, 1'b1, sp_q <= SW'(MAX_NODES))
  `BFEO_ASSERT_NEXT(a_last_starts, acc && s_axis_tlast, state_q == bfeo_pkg::ST_START)

endmodule

>>> design/bfeo_ram.sv
// single write, single registered read memory
module bfeo_ram #(
  parameter int Depth = 64,
  parameter int Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
